FILE: rtl/tga_rle_pkg.sv
// Shared types and constants for the Targa RLE stream decoder.
package tga_rle_pkg;

  localparam int unsigned MAX_PIXEL_BYTES = 4;
  localparam int unsigned BPP_W           = 3;
  localparam int unsigned LINE_W          = 16;
  localparam int unsigned COUNT_W         = 17;
  localparam int unsigned PIXEL_W         = 8 * MAX_PIXEL_BYTES;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [7:0] HDR_RUN_MASK = 8'h80;
  localparam logic [7:0] HDR_LEN_MASK = 8'h7f;

  typedef enum logic [1:0] {
    REG_BYTES_PER_PIXEL = 2'd0,
    REG_LINE_WIDTH      = 2'd1,
    REG_LINE_TOTAL      = 2'd2,
    REG_RLE_ENABLED     = 2'd3
  } tga_reg_e;

  typedef struct packed {
    logic [BPP_W-1:0]  bytes_per_pixel;
    logic [LINE_W-1:0] line_width;
    logic [LINE_W-1:0] line_total;
    logic              rle_enabled;
  } tga_cfg_t;

  typedef struct packed {
    logic               awaiting_header;
    logic               run_packet;
    logic [7:0]         pixels_left;
    logic [1:0]         byte_in_pixel;
    logic [PIXEL_W-1:0] assembly;
    logic [COUNT_W-1:0] pixels_in_line;
    logic [LINE_W-1:0]  rows_done;
  } tga_state_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_value;
    logic [7:0]         repeat_count;
    logic               end_of_line;
    logic               end_of_image;
  } tga_res_t;

endpackage

FILE: rtl/tga_rle_step.sv
// Next-state and result logic for one stream byte.
module tga_rle_step (
  input  tga_rle_pkg::tga_cfg_t   cfg_i,
  input  tga_rle_pkg::tga_state_t state_i,
  input  logic [7:0]              stream_byte_i,
  output tga_rle_pkg::tga_state_t state_o,
  output logic                    emit_o,
  output tga_rle_pkg::tga_res_t   res_o
);
  import tga_rle_pkg::*;

  logic               is_header;
  logic [2:0]         pix_size;
  logic [2:0]         byte_count;
  logic               pixel_last;
  logic [PIXEL_W-1:0] assembly;
  logic [7:0]         repeat_cnt;
  logic [7:0]         left_dec;
  logic               packet_done;
  logic [COUNT_W:0]   line_sum;
  logic [COUNT_W-1:0] line_sat;
  logic [LINE_W:0]    rows_inc;
  logic               eol;
  logic               eoi;

  assign is_header  = cfg_i.rle_enabled && state_i.awaiting_header;
  assign byte_count = {1'b0, state_i.byte_in_pixel} + 3'd1;
  assign pixel_last = byte_count >= pix_size;
  assign emit_o     = !is_header && pixel_last;

  always_comb begin
    if (cfg_i.bytes_per_pixel == '0) begin
      pix_size = 3'd1;
    end else if (cfg_i.bytes_per_pixel > BPP_W'(MAX_PIXEL_BYTES)) begin
      pix_size = 3'(MAX_PIXEL_BYTES);
    end else begin
      pix_size = cfg_i.bytes_per_pixel;
    end
  end

  // first byte of a pixel clears the stale upper lanes
  always_comb begin
    if (state_i.byte_in_pixel == 2'd0) begin
      assembly = {{(PIXEL_W-8){1'b0}}, stream_byte_i};
    end else begin
      assembly = state_i.assembly |
                 ({{(PIXEL_W-8){1'b0}}, stream_byte_i} << {state_i.byte_in_pixel, 3'b000});
    end
  end

  assign left_dec = (state_i.pixels_left != 8'd0) ? state_i.pixels_left - 8'd1 : 8'd0;

  always_comb begin
    if (!cfg_i.rle_enabled) begin
      repeat_cnt  = 8'd1;
      packet_done = 1'b1;
    end else if (state_i.run_packet) begin
      repeat_cnt  = (state_i.pixels_left == 8'd0) ? 8'd1 : state_i.pixels_left;
      packet_done = 1'b1;
    end else begin
      repeat_cnt  = 8'd1;
      packet_done = (left_dec == 8'd0);
    end
  end

  assign line_sum = {1'b0, state_i.pixels_in_line} + {{(COUNT_W-7){1'b0}}, repeat_cnt};
  assign line_sat = line_sum[COUNT_W] ? '1 : line_sum[COUNT_W-1:0];
  assign eol      = packet_done && (line_sat >= {1'b0, cfg_i.line_width});
  assign rows_inc = {1'b0, state_i.rows_done} + 17'd1;
  assign eoi      = eol && (rows_inc >= {1'b0, cfg_i.line_total});

  always_comb begin
    state_o = state_i;
    if (is_header) begin
      state_o.run_packet      = (stream_byte_i & HDR_RUN_MASK) != 8'd0;
      state_o.pixels_left     = (stream_byte_i & HDR_LEN_MASK) + 8'd1;
      state_o.awaiting_header = 1'b0;
      state_o.byte_in_pixel   = 2'd0;
      state_o.assembly        = '0;
    end else begin
      state_o.assembly = assembly;
      if (!pixel_last) begin
        state_o.byte_in_pixel = byte_count[1:0];
      end else begin
        state_o.byte_in_pixel = 2'd0;
        if (cfg_i.rle_enabled) begin
          if (state_i.run_packet) begin
            state_o.pixels_left     = 8'd0;
            state_o.awaiting_header = 1'b1;
          end else begin
            state_o.pixels_left = left_dec;
            if (packet_done) begin
              state_o.awaiting_header = 1'b1;
            end
          end
        end
        state_o.pixels_in_line = eol ? '0 : line_sat;
        if (eol) begin
          state_o.rows_done = eoi ? '0 : rows_inc[LINE_W-1:0];
        end
      end
    end
  end

  assign res_o.pixel_value  = assembly;
  assign res_o.repeat_count = repeat_cnt;
  assign res_o.end_of_line  = eol;
  assign res_o.end_of_image = eoi;

endmodule

FILE: rtl/tga_rle_decoder.sv
// Top level of the Targa RLE stream decoder: config registers, state and output word register.
// A pixel word appears on the output in the cycle after its last byte is accepted.
// Throughput: one stream byte per cycle; header and inner pixel bytes never wait on the output.
// A byte that completes a pixel stalls only while the output register holds an untaken word.
// Reset (async, active low) clears decoder state and loads register defaults 1,1,1,1.
module tga_rle_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          stream_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tga_rle_pkg::PIXEL_W-1:0]     pixel_value_o,
  output logic [7:0]                          repeat_count_o,
  output logic                                end_of_line_o,
  output logic                                end_of_image_o
);
  import tga_rle_pkg::*;

  tga_cfg_t   cfg_q, cfg_d;
  tga_state_t state_q, state_d;
  tga_res_t   res_q, res_d;
  logic       out_valid_q, out_valid_d;
  logic       emit;
  logic       in_fire;

  tga_rle_step u_step (
    .cfg_i         (cfg_q),
    .state_i       (state_q),
    .stream_byte_i (stream_byte_i),
    .state_o       (state_d),
    .emit_o        (emit),
    .res_o         (res_d)
  );

  // emit depends only on registered config and state, so ready never looks at valid
  assign in_ready_o = !emit || !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (tga_reg_e'(cfg_idx_i))
        REG_BYTES_PER_PIXEL: cfg_d.bytes_per_pixel = cfg_data_i[BPP_W-1:0];
        REG_LINE_WIDTH:      cfg_d.line_width      = cfg_data_i[LINE_W-1:0];
        REG_LINE_TOTAL:      cfg_d.line_total      = cfg_data_i[LINE_W-1:0];
        REG_RLE_ENABLED:     cfg_d.rle_enabled     = cfg_data_i[0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_pixel   <= BPP_W'(1);
      cfg_q.line_width        <= LINE_W'(1);
      cfg_q.line_total        <= LINE_W'(1);
      cfg_q.rle_enabled       <= 1'b1;
      state_q.awaiting_header <= 1'b1;
      state_q.run_packet      <= 1'b0;
      state_q.pixels_left     <= '0;
      state_q.byte_in_pixel   <= '0;
      state_q.assembly        <= '0;
      state_q.pixels_in_line  <= '0;
      state_q.rows_done       <= '0;
      out_valid_q             <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = res_q.pixel_value;
  assign repeat_count_o = res_q.repeat_count;
  assign end_of_line_o  = res_q.end_of_line;
  assign end_of_image_o = res_q.end_of_image;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && emit && out_valid_q && !out_ready_i))
    else $error("pixel word overwritten while waiting");

  a_eoi_has_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!end_of_image_o || end_of_line_o))
    else $error("end of image without end of line");

  a_repeat_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (repeat_count_o != 8'd0))
    else $error("zero repeat count");

  a_header_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cfg_q.rle_enabled && state_q.awaiting_header) |=> !state_q.awaiting_header)
    else $error("header byte did not open a packet");

endmodule

FILE: tb/tga_rle_checker.sv
// Pixel word checker for the Targa RLE decoder: tracks config writes, predicts and compares.
module tga_rle_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [7:0]                         stream_byte_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [tga_rle_pkg::PIXEL_W-1:0]    pixel_value_i,
  input  logic [7:0]                         repeat_count_i,
  input  logic                               end_of_line_i,
  input  logic                               end_of_image_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 pixel_words_o,
  output int                                 line_ends_o,
  output int                                 image_ends_o
);
  import tga_rle_pkg::*;

  tga_cfg_t   cfg;
  tga_state_t st;
  tga_res_t   expected_pixels[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR word %0d %s: got 0x%0h, expected 0x%0h", pixel_words_o, what, got, want);
    fail_count_o++;
  endtask

  task automatic reset_decoder();
    cfg.bytes_per_pixel = 3'd1;
    cfg.line_width      = 16'd1;
    cfg.line_total      = 16'd1;
    cfg.rle_enabled     = 1'b1;
    st                  = '0;
    st.awaiting_header  = 1'b1;
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_BYTES_PER_PIXEL: cfg.bytes_per_pixel = data[BPP_W-1:0];
      REG_LINE_WIDTH:      cfg.line_width      = data[LINE_W-1:0];
      REG_LINE_TOTAL:      cfg.line_total      = data[LINE_W-1:0];
      REG_RLE_ENABLED:     cfg.rle_enabled     = data[0];
      default: ;
    endcase
  endtask

  // Advances the decoder by one stream byte; has_pixel tells whether a word comes out.
  task automatic decode_byte(input logic [7:0] b, output bit has_pixel, output tga_res_t px);
    logic [2:0]  cnt;
    logic [2:0]  size;
    logic [7:0]  rep;
    logic [17:0] sum;
    bit          done;
    has_pixel = 1'b0;
    px        = '0;
    if (cfg.rle_enabled && st.awaiting_header) begin
      st.run_packet      = (b & HDR_RUN_MASK) != 8'd0;
      st.pixels_left     = (b & HDR_LEN_MASK) + 8'd1;
      st.awaiting_header = 1'b0;
      st.byte_in_pixel   = 2'd0;
      st.assembly        = '0;
      return;
    end
    if (st.byte_in_pixel == 2'd0)
      st.assembly = PIXEL_W'(b);
    else
      st.assembly = st.assembly | (PIXEL_W'(b) << {st.byte_in_pixel, 3'b000});
    cnt  = {1'b0, st.byte_in_pixel} + 3'd1;
    size = cfg.bytes_per_pixel;
    if (size == 3'd0) size = 3'd1;
    if (size > 3'(MAX_PIXEL_BYTES)) size = 3'(MAX_PIXEL_BYTES);
    if (cnt < size) begin
      st.byte_in_pixel = cnt[1:0];
      return;
    end
    st.byte_in_pixel = 2'd0;

    if (!cfg.rle_enabled) begin
      rep  = 8'd1;
      done = 1'b1;
    end else if (st.run_packet) begin
      rep = st.pixels_left;
      if (rep == 8'd0) rep = 8'd1;
      st.pixels_left     = 8'd0;
      st.awaiting_header = 1'b1;
      done               = 1'b1;
    end else begin
      rep = 8'd1;
      if (st.pixels_left != 8'd0) st.pixels_left = st.pixels_left - 8'd1;
      done = st.pixels_left == 8'd0;
      if (done) st.awaiting_header = 1'b1;
    end

    sum = {1'b0, st.pixels_in_line} + 18'(rep);
    if (sum > 18'h1ffff) sum = 18'h1ffff;
    st.pixels_in_line = sum[COUNT_W-1:0];
    // literal packets end the row only once the whole packet is in
    if (done && st.pixels_in_line >= COUNT_W'(cfg.line_width)) begin
      px.end_of_line    = 1'b1;
      st.pixels_in_line = '0;
      if ({1'b0, st.rows_done} + 17'd1 >= {1'b0, cfg.line_total}) begin
        px.end_of_image = 1'b1;
        st.rows_done    = '0;
      end else begin
        st.rows_done = st.rows_done + 16'd1;
      end
    end
    px.pixel_value  = st.assembly;
    px.repeat_count = rep;
    has_pixel       = 1'b1;
  endtask

  task automatic check_word();
    tga_res_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch("unexpected pixel word", pixel_value_i, 32'd0);
      return;
    end
    want = expected_pixels.pop_front();
    if (pixel_value_i !== want.pixel_value)
      report_mismatch("pixel_value", pixel_value_i, want.pixel_value);
    if (repeat_count_i !== want.repeat_count)
      report_mismatch("repeat_count", 32'(repeat_count_i), 32'(want.repeat_count));
    if (end_of_line_i !== want.end_of_line)
      report_mismatch("end_of_line", 32'(end_of_line_i), 32'(want.end_of_line));
    if (end_of_image_i !== want.end_of_image)
      report_mismatch("end_of_image", 32'(end_of_image_i), 32'(want.end_of_image));
    pixel_words_o++;
    line_ends_o  += int'(want.end_of_line);
    image_ends_o += int'(want.end_of_image);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit       got;
    tga_res_t px;
    if (!rst_ni) begin
      reset_decoder();
      expected_pixels.delete();
      fail_count_o  = 0;
      pixel_words_o = 0;
      line_ends_o   = 0;
      image_ends_o  = 0;
    end else begin
      // the word leaving now is older than anything accepted at this edge
      if (out_valid_i && out_ready_i) check_word();
      // a byte taken at this edge still sees the old registers
      if (in_valid_i && in_ready_i) begin
        decode_byte(stream_byte_i, got, px);
        if (got) expected_pixels.push_back(px);
      end
      if (cfg_we_i) write_register(cfg_idx_i, cfg_data_i);
    end
    pending_o = expected_pixels.size();
  end

endmodule

FILE: tb/tb.sv
// Testbench top for the Targa RLE decoder: clock, reset, stream stimulus and verdict.
module tb;
  import tga_rle_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int SEGMENT_BYTES  = 80;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [1:0]            cfg_idx_i      = REG_BYTES_PER_PIXEL;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            stream_byte_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [PIXEL_W-1:0]    pixel_value_o;
  logic [7:0]            repeat_count_o;
  logic                  end_of_line_o;
  logic                  end_of_image_o;

  int fail_count;
  int pixels_pending;
  int pixel_words;
  int line_ends;
  int image_ends;

  int send_idle_pct = 24;
  int recv_idle_pct = 88;
  int bytes_sent    = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;
  int bpp_eff       = 1;

  tga_rle_decoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .stream_byte_i  (stream_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_value_o  (pixel_value_o),
    .repeat_count_o (repeat_count_o),
    .end_of_line_o  (end_of_line_o),
    .end_of_image_o (end_of_image_o)
  );

  tga_rle_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .stream_byte_i  (stream_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_value_i  (pixel_value_o),
    .repeat_count_i (repeat_count_o),
    .end_of_line_i  (end_of_line_o),
    .end_of_image_i (end_of_image_o),
    .fail_count_o   (fail_count),
    .pending_o      (pixels_pending),
    .pixel_words_o  (pixel_words),
    .line_ends_o    (line_ends),
    .image_ends_o   (image_ends)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // valid is only lowered in a gap cycle, so back-to-back bytes keep it high
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // hold the stream until every predicted pixel word has come out
  task automatic drain_decoder();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pixels_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [2:0] bpp, input logic [15:0] width,
                          input logic [15:0] total, input logic rle);
    drain_decoder();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_BYTES_PER_PIXEL;
    cfg_data_i <= {13'($urandom), bpp};
    @(posedge clk_i);
    cfg_idx_i  <= REG_LINE_WIDTH;
    cfg_data_i <= width;
    @(posedge clk_i);
    cfg_idx_i  <= REG_LINE_TOTAL;
    cfg_data_i <= total;
    @(posedge clk_i);
    cfg_idx_i  <= REG_RLE_ENABLED;
    cfg_data_i <= {15'($urandom), rle};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    bpp_eff = (bpp == 3'd0) ? 1 : ((bpp > 3'(MAX_PIXEL_BYTES)) ? MAX_PIXEL_BYTES : int'(bpp));
    settings_used++;
  endtask

  task automatic send_packet();
    int unsigned len;
    bit          run;
    int unsigned npix;
    len  = ($urandom_range(19) == 0) ? $urandom_range(127) : $urandom_range(7);
    run  = 1'($urandom_range(1));
    send_byte({run, 7'(len)});
    npix = run ? 1 : len + 1;
    repeat (npix * bpp_eff) send_byte(8'($urandom));
  endtask

  initial begin
    logic [2:0]  bpp;
    logic [15:0] width;
    logic [15:0] total;
    logic        rle;
    int          seg_end;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults: single byte pixels, one pixel per row, one row per image
    send_byte(8'h80); send_byte(8'hff);
    send_byte(8'hff); send_byte(8'h00);               // longest run
    send_byte(8'h01); send_byte(8'ha5); send_byte(8'h5a);
    // zero width and zero rows, zero pixel size acting as one byte
    set_regs(3'd0, 16'd0, 16'd0, 1'b1);
    send_byte(8'h00); send_byte(8'h3c);
    // oversized pixel size clamps to four bytes, raw mode, widest row
    set_regs(3'd7, 16'hffff, 16'hffff, 1'b0);
    send_byte(8'h01); send_byte(8'h02); send_byte(8'h03); send_byte(8'h04);
    // mode switch in the middle of a literal packet; row reached inside the packet
    set_regs(3'd2, 16'd1, 16'd2, 1'b1);
    send_byte(8'h02); send_byte(8'h11); send_byte(8'h22);
    set_regs(3'd2, 16'd1, 16'd2, 1'b0);
    send_byte(8'h33); send_byte(8'h44);
    set_regs(3'd2, 16'd1, 16'd2, 1'b1);
    send_byte(8'h55); send_byte(8'h66); send_byte(8'h77); send_byte(8'h88);
    // pixel size shrinks while a pixel is half assembled
    set_regs(3'd4, 16'd3, 16'd3, 1'b1);
    send_byte(8'h80); send_byte(8'h12); send_byte(8'h34);
    set_regs(3'd2, 16'd3, 16'd3, 1'b1);
    send_byte(8'h56);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : ((phase == 1) ? 88 : 0);
      recv_idle_pct = (phase == 0) ? 88 : ((phase == 1) ? 24 : 0);
      for (int seg = 0; seg < 7; seg++) begin
        bpp = 3'($urandom_range(7));
        case ($urandom_range(9))
          0:       width = 16'd0;
          1:       width = 16'hffff;
          default: width = 16'($urandom_range(1, 24));
        endcase
        case ($urandom_range(9))
          0:       total = 16'd0;
          1:       total = 16'hffff;
          default: total = 16'($urandom_range(1, 4));
        endcase
        rle = ($urandom_range(3) != 0);
        set_regs(bpp, width, total, rle);
        seg_end = bytes_sent + SEGMENT_BYTES;
        while (bytes_sent < seg_end) begin
          if (!rle)
            send_byte(8'($urandom));
          else if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom));   // stray bytes
          else
            send_packet();
          if ($urandom_range(199) == 0) drain_decoder();
        end
      end
    end

    drain_decoder();
    @(negedge clk_i);
    $display("Covered %0d stream bytes under %0d register settings and three stall patterns.",
             bytes_sent, settings_used);
    $display("Checked %0d pixel words, %0d line ends, %0d image ends.",
             pixel_words, line_ends, image_ends);
    if (fail_count == 0 && pixels_pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
rtl/tga_rle_pkg.sv
rtl/tga_rle_step.sv
rtl/tga_rle_decoder.sv
tb/tga_rle_checker.sv
tb/tb.sv
